/* hdl/iswc_pkg.sv */
// shared types and constants for the insertion sort block
package iswc_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int VALUE_W     = 32;
   localparam int CMP_W       = 11;
   localparam int MOVE_W      = 12;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_run;
      logic [CMP_W-1:0]          comparisons;
      logic [MOVE_W-1:0]         moves;
      logic                      overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mark_drop;
      logic scan_read;
      logic scan_cmp;
      logic place;
      logic emit_read;
      logic emit_out;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic fill_zero;
      logic is_last;
      logic greater;
      logic loc_one;
      logic emit_end;
   } dp_status_type;

endpackage

/* hdl/iswc_ctrl.sv */
// controller state machine for the insertion sort block
module iswc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output iswc_pkg::dp_cmd_type   cmd,
   input  iswc_pkg::dp_status_type status
);
   import iswc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.full) begin
               state_in = status.is_last ? ST_EMIT_RD : ST_IDLE;
            end else if (status.fill_zero) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (status.greater && !status.loc_one) state_in = ST_SCAN_RD;
            else state_in = ST_PLACE;
         end
         ST_PLACE: begin
            state_in = status.is_last ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            state_in = status.emit_end ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_DECIDE: begin
            cmd.mark_drop = status.full;
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
         end
         ST_EMIT_OUT: begin
            cmd.emit_out = 1'b1;
            rsp_strobe   = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* hdl/iswc_datapath.sv */
// sorted store, scan pointer and work counters
module iswc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  iswc_pkg::req_type       req_data,
   input  iswc_pkg::dp_cmd_type    cmd,
   output iswc_pkg::dp_status_type status,
   output iswc_pkg::rsp_type       rsp_data
);
   import iswc_pkg::*;

   localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_ITEMS);

   logic signed [VALUE_W-1:0] mem [STORE_DEPTH];
   logic signed [VALUE_W-1:0] rd_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      last_ff;
   logic [CNT_W-1:0]          loc_ff;
   logic [CNT_W-1:0]          loc_in;
   logic [CNT_W-1:0]          fill_ff;
   logic [CNT_W-1:0]          fill_in;
   logic [ADDR_W-1:0]         idx_ff;
   logic [ADDR_W-1:0]         idx_in;
   logic [CMP_W-1:0]          comp_ff;
   logic [CMP_W-1:0]          comp_in;
   logic [MOVE_W-1:0]         move_ff;
   logic [MOVE_W-1:0]         move_in;
   logic                      drop_ff;
   logic                      drop_in;
   logic [CNT_W-1:0]          loc_dec;
   logic [ADDR_W-1:0]         raddr;
   logic                      greater;
   logic                      emit_end;

   assign loc_dec  = loc_ff - CNT_W'(1);
   assign greater  = rd_ff > value_ff;
   assign emit_end = ({1'b0, idx_ff} + CNT_W'(1)) == fill_ff;
   assign raddr    = cmd.emit_read ? idx_ff : loc_dec[ADDR_W-1:0];

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.scan_cmp && greater) begin
         mem[loc_ff[ADDR_W-1:0]] <= rd_ff;
      end else if (cmd.place) begin
         mem[loc_ff[ADDR_W-1:0]] <= value_ff;
      end
      if (cmd.scan_read || cmd.emit_read) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_data.value;
         last_ff  <= req_data.is_last;
      end
      loc_ff <= loc_in;
   end

   always_comb begin
      loc_in = loc_ff;
      if (cmd.capture) loc_in = fill_ff;
      else if (cmd.scan_cmp && greater) loc_in = loc_dec;
   end

   always_comb begin
      fill_in = fill_ff;
      idx_in  = idx_ff;
      comp_in = comp_ff;
      move_in = move_ff;
      drop_in = drop_ff;
      if (cmd.mark_drop) drop_in = 1'b1;
      if (cmd.scan_cmp) begin
         comp_in = comp_ff + CMP_W'(1);
         if (greater) move_in = move_ff + MOVE_W'(1);
      end
      if (cmd.place) begin
         fill_in = fill_ff + CNT_W'(1);
         if (fill_ff != '0) move_in = move_ff + MOVE_W'(2);
      end
      if (cmd.emit_out) begin
         idx_in = idx_ff + ADDR_W'(1);
         if (emit_end) begin
            fill_in = '0;
            idx_in  = '0;
            comp_in = '0;
            move_in = '0;
            drop_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff  <= '0;
         comp_ff <= '0;
         move_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
         comp_ff <= comp_in;
         move_ff <= move_in;
         drop_ff <= drop_in;
      end
   end

   always_comb begin
      status.full      = fill_ff == MaxCount;
      status.fill_zero = fill_ff == '0;
      status.is_last   = last_ff;
      status.greater   = greater;
      status.loc_one   = loc_ff == CNT_W'(1);
      status.emit_end  = emit_end;
   end

   always_comb begin
      rsp_data.sorted_value = rd_ff;
      rsp_data.end_of_run   = emit_end;
      rsp_data.comparisons  = comp_ff;
      rsp_data.moves        = move_ff;
      rsp_data.overflowed   = drop_ff;
   end

endmodule

/* hdl/insertion_sort_with_counts.sv */
// top level of the streaming insertion sort with comparison and move counts
// a request is scanned by a read and compare per element, then placed;
// a full store drops it; the run is emitted on the request marked last,
// each result read then output via the registered read port of the 64-entry store
// results cannot be stalled; busy stays high until the last one is out
// synchronous reset empties the store and clears both totals and the drop flag
module insertion_sort_with_counts (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iswc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output iswc_pkg::rsp_type rsp_data
);
   import iswc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   iswc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   iswc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* tb/tb_insertion_sort_with_counts.sv */
// testbench for insertion_sort_with_counts: directed and random sets checked against a predictor
`timescale 1ns / 1ps

module tb_insertion_sort_with_counts;
   import iswc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   insertion_sort_with_counts uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // predictor state
   logic signed [VALUE_W-1:0] sort_store [STORE_DEPTH];
   int      store_fill = 0;
   int      cmp_total  = 0;
   int      move_total = 0;
   logic    drop_flag  = 1'b0;
   rsp_type pending_results [$];
   int      fail_count = 0;
   int      idle_pct   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("insertion_sort_with_counts verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, want %h", what, got, want);
      fail_count++;
   endtask

   task automatic predict_request(input req_type item);
      int loc;
      int comps;
      int shifts;
      rsp_type r;
      if (store_fill < MAX_ITEMS) begin
         loc    = store_fill;
         comps  = 0;
         shifts = 0;
         while (loc > 0) begin
            comps++;
            if (!(sort_store[loc-1] > $signed(item.value))) break;
            sort_store[loc] = sort_store[loc-1];
            shifts++;
            loc--;
         end
         sort_store[loc] = item.value;
         if (store_fill > 0) begin
            cmp_total  = cmp_total + comps;
            if (cmp_total > (1 << CMP_W) - 1) cmp_total = (1 << CMP_W) - 1;
            move_total = move_total + shifts + 2;
            if (move_total > (1 << MOVE_W) - 1) move_total = (1 << MOVE_W) - 1;
         end
         store_fill++;
      end else begin
         drop_flag = 1'b1;
      end
      if (item.is_last) begin
         for (int i = 0; i < store_fill; i++) begin
            r.sorted_value = sort_store[i];
            r.end_of_run   = (i == store_fill - 1);
            r.comparisons  = cmp_total[CMP_W-1:0];
            r.moves        = move_total[MOVE_W-1:0];
            r.overflowed   = drop_flag;
            pending_results.push_back(r);
         end
         store_fill = 0;
         cmp_total  = 0;
         move_total = 0;
         drop_flag  = 1'b0;
      end
   endtask

   // returns at the edge that accepts the request, start left high
   task automatic send_request(input logic [VALUE_W-1:0] value, input logic is_last);
      req_type item;
      item.value   = value;
      item.is_last = is_last;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      predict_request(item);
   endtask

   task automatic wait_results_done();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(3))
         0, 3: return $urandom();
         1: return $urandom_range(8) - 4;
         default: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
      endcase
   endfunction

   task automatic send_set(input int len);
      for (int i = 0; i < len; i++) send_request(rand_value(), i == len - 1);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_data), 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.sorted_value !== want.sorted_value)
               report_mismatch("sorted_value", rsp_data.sorted_value, want.sorted_value);
            if (rsp_data.end_of_run !== want.end_of_run)
               report_mismatch("end_of_run", 32'(rsp_data.end_of_run), 32'(want.end_of_run));
            if (rsp_data.comparisons !== want.comparisons)
               report_mismatch("comparisons", 32'(rsp_data.comparisons),
                               32'(want.comparisons));
            if (rsp_data.moves !== want.moves)
               report_mismatch("moves", 32'(rsp_data.moves), 32'(want.moves));
            if (rsp_data.overflowed !== want.overflowed)
               report_mismatch("overflowed", 32'(rsp_data.overflowed), 32'(want.overflowed));
         end
      end
   end

   task automatic test_single_item();
      idle_pct = 0;
      send_request(32'h8000_0000, 1'b1);
      wait_results_done();
   endtask

   task automatic test_extremes();
      send_request(32'h7fff_ffff, 1'b0);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h0000_0000, 1'b0);
      send_request(32'hffff_ffff, 1'b0);
      send_request(32'h0000_0001, 1'b0);
      send_request(32'h7fff_ffff, 1'b0);
      send_request(32'h8000_0000, 1'b1);
   endtask

   task automatic test_ascending();
      send_request(-3, 1'b0);
      send_request(-2, 1'b0);
      send_request(5, 1'b0);
      send_request(9, 1'b1);
   endtask

   task automatic test_descending();
      idle_pct = 84;
      send_request(100, 1'b0);
      send_request(50, 1'b0);
      send_request(0, 1'b0);
      send_request(-50, 1'b0);
      send_request(-100, 1'b1);
   endtask

   task automatic test_equal_values();
      idle_pct = 20;
      send_request(7, 1'b0);
      send_request(7, 1'b0);
      send_request(3, 1'b0);
      send_request(7, 1'b0);
      send_request(7, 1'b1);
      wait_results_done();
   endtask

   task automatic test_random_sets();
      int pcts [3] = '{0, 84, 20};
      int sent;
      int len;
      int r;
      foreach (pcts[p]) begin
         idle_pct = pcts[p];
         sent = 0;
         while (sent < 10) begin
            r = $urandom_range(99);
            if (r < 75) len = $urandom_range(6, 1);
            else if (r < 95) len = $urandom_range(16, 7);
            else len = $urandom_range(32, 17);
            send_set(len);
            sent += len;
         end
         wait_results_done();
      end
   endtask

   task automatic test_store_full();
      idle_pct = 20;
      // strictly descending fill gives the largest totals, then drops with the last one dropped
      for (int i = 0; i < MAX_ITEMS; i++) send_request(32'h7fff_ffff - i, 1'b0);
      send_request(rand_value(), 1'b0);
      send_request(rand_value(), 1'b1);
      idle_pct = 0;
      wait_results_done();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_single_item();
      test_extremes();
      test_ascending();
      test_descending();
      test_equal_values();
      test_random_sets();
      test_store_full();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("insertion_sort_with_counts verification clean");
      end else begin
         $display("insertion_sort_with_counts verification failed");
      end
      $finish;
   end

endmodule
